@@ design/fcr_pkg.sv @@
// Shared constants for the framed command responder: frame markers and command codes.
package fcr_pkg;

    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] ACK_BYTE   = 8'h8F;
    localparam logic [7:0] ACK_LEN    = 8'h00;
    localparam logic [7:0] SMP_LEN    = 8'h02;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    localparam logic [7:0] CMD_ON     = 8'h04;
    localparam logic [7:0] CMD_OFF    = 8'h08;
    localparam logic [7:0] CMD_TOGGLE = 8'h10;
    localparam logic [7:0] CMD_SAMPLE = 8'h20;
    localparam logic [7:0] CMD_LOOP   = 8'h40;

    // Width used for position and count compares (count byte plus header fits in 9 bits).
    localparam int CMP_W = 9;

    typedef logic [7:0] byte_t;

endpackage

@@ design/framed_command_responder_top.sv @@
// Framed command responder: parses command frames from a byte stream and answers them.
//
// Each input item is one received byte (with the current 12-bit converter sample). Frames are
// 01, command, count, count parameter bytes, 8-bit sum checksum. The parser takes every byte
// offered while s_tready is high. A good frame turns the block into a responder: s_tready
// drops while the response goes out, one item per cycle when the output is not stalled for the
// fixed response bytes, and in loopback each echoed parameter waits for a read of the frame
// memory before it goes out from the registered data. Bad command, bad checksum or a parameter
// run past the frame memory drops the frame with no response. The result register lets the
// next byte be taken while the final response item waits for m_tready.
module framed_command_responder_top #(
    parameter int FRAME_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] rx_byte, [19:8] adc_sample, [23:20] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [8] led_on, [15:9] zero
    output logic        m_tlast    // tx_last
);
    import fcr_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int PW = $clog2(FRAME_DEPTH + 1);

    localparam logic ST_RX = 1'b0;
    localparam logic ST_TX = 1'b1;

    logic                state_reg, state_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [7:0]          count_reg, count_next;
    logic [7:0]          sum_reg, sum_next;
    logic [7:0]          cmd_reg, cmd_next;
    logic                led_reg, led_next;
    logic [11:0]         sample_reg, sample_next;
    logic [PW-1:0]       k_reg, k_next;
    logic [7:0]          txsum_reg, txsum_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [15:0]         m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    byte_t               mem [FRAME_DEPTH];
    byte_t               rd_data_reg;
    logic                wr_en;

    byte_t               rx_byte;
    logic [11:0]         adc_sample;
    logic                cmd_ok;
    logic                is_led, is_smp;
    logic [CMP_W-1:0]    k9, count9, pos9;
    byte_t               tx_byte;
    logic                tx_last, need_rd, out_free, advance;

    assign rx_byte    = s_tdata[7:0];
    assign adc_sample = s_tdata[19:8];

    assign s_tready = (state_reg == ST_RX);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign cmd_ok = (rx_byte == CMD_ON) || (rx_byte == CMD_OFF) || (rx_byte == CMD_TOGGLE) ||
                    (rx_byte == CMD_SAMPLE) || (rx_byte == CMD_LOOP);
    assign is_led = (cmd_reg == CMD_ON) || (cmd_reg == CMD_OFF) || (cmd_reg == CMD_TOGGLE);
    assign is_smp = (cmd_reg == CMD_SAMPLE);

    assign k9     = CMP_W'(k_reg);
    assign pos9   = CMP_W'(pos_reg);
    assign count9 = CMP_W'(count_reg);

    // Response byte for index k; the checksum is the running sum of the bytes sent before it.
    always_comb begin
        tx_byte = txsum_reg;
        tx_last = 1'b1;
        need_rd = 1'b0;
        if (k9 == CMP_W'(0)) begin
            tx_byte = START_BYTE;
            tx_last = 1'b0;
        end else if (k9 == CMP_W'(1)) begin
            tx_byte = is_led ? ACK_BYTE : cmd_reg;
            tx_last = 1'b0;
        end else if (k9 == CMP_W'(2)) begin
            tx_byte = is_led ? ACK_LEN : (is_smp ? SMP_LEN : count_reg);
            tx_last = 1'b0;
        end else if (is_smp) begin
            if (k9 == CMP_W'(3)) begin
                tx_byte = {4'b0000, sample_reg[11:8] & NIBBLE_MASK};
                tx_last = 1'b0;
            end else if (k9 == CMP_W'(4)) begin
                tx_byte = sample_reg[7:0];
                tx_last = 1'b0;
            end
        end else if (!is_led) begin
            if (k9 < count9 + CMP_W'(3)) begin
                tx_byte = rd_data_reg;
                tx_last = 1'b0;
                need_rd = 1'b1;
            end
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = (state_reg == ST_TX) && out_free && (!need_rd || rd_valid_reg);

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        cmd_next      = cmd_reg;
        led_next      = led_reg;
        sample_next   = sample_reg;
        k_next        = k_reg;
        txsum_next    = txsum_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg;
        wr_en         = 1'b0;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_RX: begin
                if (s_tvalid) begin
                    if (pos_reg == '0) begin
                        if (rx_byte == START_BYTE) begin
                            pos_next = PW'(1);
                            sum_next = rx_byte;
                        end
                    end else if (pos_reg == PW'(1)) begin
                        if (cmd_ok) begin
                            cmd_next = rx_byte;
                            pos_next = PW'(2);
                            sum_next = sum_reg + rx_byte;
                        end else begin
                            pos_next   = '0;
                            count_next = '0;
                            sum_next   = '0;
                        end
                    end else if (pos_reg == PW'(2)) begin
                        count_next = rx_byte;
                        pos_next   = PW'(3);
                        sum_next   = sum_reg + rx_byte;
                    end else if (pos9 > count9 + CMP_W'(2)) begin
                        // checksum slot; a good frame keeps the count for the loopback echo
                        pos_next   = '0;
                        sum_next   = '0;
                        if (rx_byte == sum_reg) begin
                            state_next  = ST_TX;
                            sample_next = adc_sample;
                            k_next      = '0;
                            txsum_next  = '0;
                            if (cmd_reg == CMD_ON) begin
                                led_next = 1'b1;
                            end else if (cmd_reg == CMD_OFF) begin
                                led_next = 1'b0;
                            end else if (cmd_reg == CMD_TOGGLE) begin
                                led_next = !led_reg;
                            end
                        end else begin
                            count_next = '0;
                        end
                    end else if (pos9 < CMP_W'(FRAME_DEPTH)) begin
                        wr_en    = 1'b1;
                        pos_next = PW'(pos_reg + 1'b1);
                        sum_next = sum_reg + rx_byte;
                    end else begin
                        // parameters overran the frame memory
                        pos_next   = '0;
                        count_next = '0;
                        sum_next   = '0;
                    end
                end
            end
            ST_TX: begin
                if (advance) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0000000, led_reg, tx_byte};
                    m_tlast_next  = tx_last;
                    k_next        = PW'(k_reg + 1'b1);
                    txsum_next    = txsum_reg + tx_byte;
                    if (tx_last) begin
                        state_next = ST_RX;
                    end
                end
            end
            default: begin
                state_next = ST_RX;
            end
        endcase
    end

    // read address follows k; data is good once the registered read has been taken with k held unchanged
    assign rd_valid_next = (state_reg == ST_TX) && !advance;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[pos_reg[AW-1:0]] <= rx_byte;
        end
        rd_data_reg <= mem[k_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RX;
            pos_reg      <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            led_reg      <= 1'b0;
            k_reg        <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            led_reg      <= led_next;
            k_reg        <= k_next;
            rd_valid_reg <= rd_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        sample_reg  <= sample_next;
        txsum_reg   <= txsum_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos9 <= CMP_W'(FRAME_DEPTH))
        else $error("frame position past memory depth");

    a_cmd_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos9 >= CMP_W'(3)) |-> ((cmd_reg == CMD_ON) || (cmd_reg == CMD_OFF) ||
        (cmd_reg == CMD_TOGGLE) || (cmd_reg == CMD_SAMPLE) || (cmd_reg == CMD_LOOP)))
        else $error("frame body with unknown command");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && tx_last) |=> (state_reg == ST_RX) && m_tvalid && m_tlast)
        else $error("response did not end on its last item");

endmodule
